// File: sv/dotq_pkg.sv
`timescale 1ns / 1ps

package dotq_pkg;

  // Queue geometry and field widths.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int TIME_W   = 32;
  localparam int DELAY_W  = 24;
  localparam int TAG_W    = 8;
  localparam int OP_W     = 2;
  localparam int MAX_OUT  = 16;
  localparam int EMIT_W   = $clog2(MAX_OUT + 1);

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [DELAY_W-1:0] delay_ticks;
    logic [TAG_W-1:0]   timer_tag;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] fired_tag;
    logic             rejected;
    logic             last_of_run;
  } out_item_t;

  // Commands from the sequencer to the entry store.
  typedef struct packed {
    logic              ins;
    logic              clr;
    logic              rm;
    logic [IDX_W-1:0]  rm_idx;
    logic [IDX_W-1:0]  rm_order;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] ins_deadline;
    logic [TAG_W-1:0]  ins_tag;
  } store_cmd_t;

  // Status and read data returned by the entry store.
  typedef struct packed {
    logic                full;
    logic [CAPACITY-1:0] valid_vec;
    logic [TIME_W-1:0]   rd_deadline;
    logic [TAG_W-1:0]    rd_tag;
    logic                rd_valid;
    logic [IDX_W-1:0]    rd_order;
  } store_rsp_t;

  // Running result of one scan over the store.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] best_idx;
    logic [IDX_W-1:0] best_order;
    logic [TAG_W-1:0] best_tag;
    logic [CNT_W-1:0] exp_cnt;
  } scan_res_t;

endpackage

// File: sv/dotq_store.sv
`timescale 1ns / 1ps

module dotq_store import dotq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  store_cmd_t cmd,
  output store_rsp_t rsp
);

  logic [TIME_W+TAG_W-1:0] mem [CAPACITY];
  logic [TIME_W+TAG_W-1:0] rd_data_r;
  logic [CAPACITY-1:0]     valid_r;
  logic [IDX_W-1:0]        order_r [CAPACITY];
  logic                    rd_valid_r;
  logic [IDX_W-1:0]        rd_order_r;
  logic [IDX_W-1:0]        free_slot;
  logic [CNT_W-1:0]        fill_cnt;

  // Lowest free slot and number of pending timers.
  always_comb begin
    free_slot = '0;
    fill_cnt  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = IDX_W'(i);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      fill_cnt = fill_cnt + CNT_W'(valid_r[i]);
    end
  end

  // Deadline and tag memory, one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      mem[free_slot] <= {cmd.ins_deadline, cmd.ins_tag};
    end
    if (cmd.rd_en) begin
      rd_data_r  <= mem[cmd.rd_addr];
      rd_valid_r <= valid_r[cmd.rd_addr];
      rd_order_r <= order_r[cmd.rd_addr];
    end
  end

  // Occupancy flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.ins) begin
      valid_r[free_slot] <= 1'b1;
    end else if (cmd.rm) begin
      valid_r[cmd.rm_idx] <= 1'b0;
    end
  end

  // Insertion ranks: a new timer ranks last, and younger ranks close up on removal.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.rm && valid_r[i] && (order_r[i] > cmd.rm_order)) begin
        order_r[i] <= order_r[i] - 1'b1;
      end
    end
    if (cmd.ins) begin
      order_r[free_slot] <= fill_cnt[IDX_W-1:0];
    end
  end

  assign rsp.full        = &valid_r;
  assign rsp.valid_vec   = valid_r;
  assign rsp.rd_deadline = rd_data_r[TIME_W+TAG_W-1:TAG_W];
  assign rsp.rd_tag      = rd_data_r[TAG_W-1:0];
  assign rsp.rd_valid    = rd_valid_r;
  assign rsp.rd_order    = rd_order_r;

endmodule

// File: sv/dotq_scan.sv
`timescale 1ns / 1ps

module dotq_scan import dotq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              chk_v,
  input  logic [IDX_W-1:0]  chk_idx,
  input  logic [TIME_W-1:0] cur_time,
  input  store_rsp_t        rsp,
  output scan_res_t         res
);

  logic              found_r;
  logic [CNT_W-1:0]  exp_cnt_r;
  logic [TIME_W-1:0] best_rem_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [IDX_W-1:0]  best_order_r;
  logic [TAG_W-1:0]  best_tag_r;
  logic [TIME_W-1:0] rem;
  logic              expired;
  logic              better;
  logic              take;

  // Remaining time as a signed difference; zero or negative means due.
  always_comb begin
    rem     = rsp.rd_deadline - cur_time;
    expired = rem[TIME_W-1] || (rem == '0);
    better  = !found_r || ($signed(rem) < $signed(best_rem_r)) ||
              ((rem == best_rem_r) && (rsp.rd_order < best_order_r));
    take    = chk_v && rsp.rd_valid && expired;
  end

  // Count of due timers and whether a candidate exists.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      exp_cnt_r <= '0;
    end else if (start) begin
      found_r   <= 1'b0;
      exp_cnt_r <= '0;
    end else if (take) begin
      exp_cnt_r <= exp_cnt_r + 1'b1;
      if (better) begin
        found_r <= 1'b1;
      end
    end
  end

  // Best candidate so far: earliest deadline, then oldest insertion.
  always_ff @(posedge clk) begin
    if (!start && take && better) begin
      best_rem_r   <= rem;
      best_idx_r   <= chk_idx;
      best_order_r <= rsp.rd_order;
      best_tag_r   <= rsp.rd_tag;
    end
  end

  assign res.found      = found_r;
  assign res.best_idx   = best_idx_r;
  assign res.best_order = best_order_r;
  assign res.best_tag   = best_tag_r;
  assign res.exp_cnt    = exp_cnt_r;

endmodule

// File: sv/deadline_ordered_timer_queue_top.sv
`timescale 1ns / 1ps

// Queue of up to CAPACITY one-shot timers ordered by deadline.
// Input channel in_valid/in_stall/in_data carries set, tick and clear items;
// the result channel out_valid/out_stall/out_data carries fired or rejected tags.
// A transfer happens on a rising edge with valid high and stall low.
// Set on a queue that is not full and clear do not stall the input. A set on a full queue yields
// one rejected result, which passes through the pending-result register and then the output register.
// A tick advances the time and then scans the deadline memory, once when nothing
// is due and once per expiry otherwise: each scan reads one entry a cycle through
// the single read port, and each expiry found is then loaded into the output register.
// At most MAX_OUT timers fire per tick; the rest stay due for later ticks.
// in_stall is high while a tick or a rejection is being worked on.
// When the receiver stalls, the result holds in the output register and the
// scan for the next expiry waits until it is taken.
// Reset clears the time, empties the queue and drops any pending result.
module deadline_ordered_timer_queue_top import dotq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r;
  logic [TIME_W-1:0] time_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              chk_v_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic [EMIT_W-1:0] emit_n_r;
  out_item_t         res_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  store_cmd_t cmd;
  store_rsp_t rsp;
  scan_res_t  scan;
  logic       in_fire;
  logic       out_free;
  logic       scan_start;
  logic       scan_done;
  logic       emit_load;
  logic       run_last;

  dotq_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  dotq_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .chk_v    (chk_v_r),
    .chk_idx  (chk_idx_r),
    .cur_time (time_r),
    .rsp      (rsp),
    .res      (scan)
  );

  // Handshake and sequencing conditions.
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    in_fire    = in_valid && !in_stall;
    out_free   = !out_valid_r || !out_stall;
    scan_done  = (state_r == ST_SCAN) && (scan_cnt_r == CNT_W'(CAPACITY)) && !chk_v_r;
    emit_load  = (state_r == ST_EMIT) && out_free;
    run_last   = (scan.exp_cnt == CNT_W'(1)) || (emit_n_r == EMIT_W'(MAX_OUT - 1));
    scan_start = (in_fire && (in_data.opcode == OP_TICK)) ||
                 (emit_load && !res_r.rejected && !res_r.last_of_run);
  end

  // Commands to the entry store.
  always_comb begin
    cmd              = '0;
    cmd.ins_deadline = time_r + TIME_W'(in_data.delay_ticks);
    cmd.ins_tag      = in_data.timer_tag;
    cmd.rd_addr      = scan_cnt_r[IDX_W-1:0];
    cmd.rm_idx       = scan.best_idx;
    cmd.rm_order     = scan.best_order;
    cmd.ins          = in_fire && (in_data.opcode == OP_SET) && !rsp.full;
    cmd.clr          = in_fire && (in_data.opcode == OP_CLEAR);
    cmd.rd_en        = (state_r == ST_SCAN) && (scan_cnt_r != CNT_W'(CAPACITY));
    cmd.rm           = emit_load && !res_r.rejected;
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      time_r     <= '0;
      scan_cnt_r <= '0;
      chk_v_r    <= 1'b0;
      emit_n_r   <= '0;
    end else begin
      chk_v_r <= cmd.rd_en;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data.opcode == OP_SET && rsp.full) begin
              state_r <= ST_EMIT;
            end else if (in_data.opcode == OP_TICK) begin
              time_r     <= time_r + 1'b1;
              scan_cnt_r <= '0;
              emit_n_r   <= '0;
              state_r    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cmd.rd_en) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
          if (scan_done) begin
            state_r <= scan.found ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (res_r.rejected || res_r.last_of_run) begin
              state_r <= ST_IDLE;
            end else begin
              scan_cnt_r <= '0;
              emit_n_r   <= emit_n_r + 1'b1;
              state_r    <= ST_SCAN;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Pending result and index of the entry in the read stage.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      chk_idx_r <= cmd.rd_addr;
    end
    if (in_fire && (in_data.opcode == OP_SET) && rsp.full) begin
      res_r <= '{fired_tag: in_data.timer_tag, rejected: 1'b1, last_of_run: 1'b1};
    end else if (scan_done) begin
      res_r <= '{fired_tag: scan.best_tag, rejected: 1'b0, last_of_run: run_last};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit_load;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A timer is only removed from an occupied slot.
  a_rm_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rm |-> rsp.valid_vec[cmd.rm_idx])
    else $error("timer removed from an empty slot");

  // A clear transfer empties the queue.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |=> (rsp.valid_vec == '0))
    else $error("queue not empty after clear");

  // No more than the limit of expiries per tick.
  a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_n_r <= EMIT_W'(MAX_OUT - 1))
    else $error("too many expiries on one tick");

  // A rejection always closes its run.
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.rejected || out_data_r.last_of_run))
    else $error("rejected result not marked last");

endmodule
